// ===== rtl/svn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svn_pkg
// Shared types and constants of the smooth vertex normal block.
// ----------------------------------------------------------------------------
package svn_pkg;

  localparam int MAX_VERTICES_DEF = 4096;
  localparam int POS_WIDTH_DEF    = 16;
  localparam int SUM_WIDTH_DEF    = 24;

  localparam int NRM_W   = 16;
  localparam int IN_IDXW = 12;
  localparam int CNT_W   = 13;
  localparam int IN_POSW = 16;

  localparam logic [CNT_W-1:0] VCOUNT_RESET = 13'd4096;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TRI  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_POS0, S_POS1, S_POS2, S_POS3, S_MUL,
    S_SUMRD, S_SUMCAP, S_START, S_WAIT, S_ACCRD, S_ACCWR, S_RESP
  } svn_state_t;

  typedef enum logic [2:0] {
    U_IDLE, U_NORM, U_SQ, U_ROOT, U_DSET, U_DIV, U_DONE
  } unit_state_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic                    zero;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } unit_res_t;

endpackage

// ===== rtl/svn_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svn_unit
// Iterative unit-length scaling of a 3-vector to Q1.14: one-bit normalizing
// shifter, squared sum, bit-serial square root and restoring divider.
// ----------------------------------------------------------------------------
module svn_unit import svn_pkg::*; #(
  parameter int VEC_W = 35
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [VEC_W-1:0] vec [3],
  output unit_res_t               res
);

  localparam int W = (VEC_W > 30) ? VEC_W : 30;
  localparam logic [W:0] HI_LIM = (W+1)'(1) << 30;
  localparam logic [W:0] LO_LIM = (W+1)'(1) << 29;

  unit_state_t state_r, state_nxt;

  logic [W-1:0]  mag_r [3];
  logic          neg_r [3];
  logic [W-1:0]  top;
  logic [1:0]    cnt_r;
  logic [59:0]   prod_r;
  logic [61:0]   sq_r;
  logic [61:0]   v_r;
  logic [61:0]   r_r;
  logic [61:0]   bit_r;
  logic [61:0]   rb;
  logic [30:0]   len_r;
  logic [30:0]   rem_r;
  logic [15:0]   num_r;
  logic [15:0]   q_r;
  logic [3:0]    dstep_r;
  logic [31:0]   trial;
  logic          take;
  logic [15:0]   q_new;
  logic [44:0]   numer;
  logic          zero_r;
  logic signed [NRM_W-1:0] out_r [3];
  logic          vec_zero;

  assign vec_zero = (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);

  always_comb begin
    top = mag_r[0];
    if (mag_r[1] > top) top = mag_r[1];
    if (mag_r[2] > top) top = mag_r[2];
  end

  assign rb    = r_r + bit_r;
  assign trial = {rem_r, num_r[15]};
  assign take  = trial >= {1'b0, len_r};
  assign q_new = {q_r[14:0], take};
  assign numer = (45'(mag_r[cnt_r][29:0]) << 14) + 45'(len_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= U_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      U_IDLE: if (start) state_nxt = vec_zero ? U_DONE : U_NORM;
      U_NORM: if (({1'b0, top} < HI_LIM) && ({1'b0, top} >= LO_LIM)) state_nxt = U_SQ;
      U_SQ:   if (cnt_r == 2'd3) state_nxt = U_ROOT;
      U_ROOT: if (bit_r[0]) state_nxt = U_DSET;
      U_DSET: state_nxt = U_DIV;
      U_DIV:  if (dstep_r == 4'd15) state_nxt = (cnt_r == 2'd2) ? U_DONE : U_DSET;
      U_DONE: state_nxt = U_IDLE;
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      U_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= vec[i][VEC_W-1];
            mag_r[i] <= W'(vec[i][VEC_W-1] ? VEC_W'(-vec[i]) : VEC_W'(vec[i]));
            out_r[i] <= '0;
          end
          zero_r <= vec_zero;
          cnt_r  <= 2'd0;
          sq_r   <= '0;
        end
      end
      U_NORM: begin
        // Right shifts truncate each magnitude toward zero and left shifts fill with zeros, one bit a step.
        if ({1'b0, top} >= HI_LIM) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
        end else if ({1'b0, top} < LO_LIM) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
        end
      end
      U_SQ: begin
        if (cnt_r != 2'd3) prod_r <= mag_r[cnt_r][29:0] * mag_r[cnt_r][29:0];
        if (cnt_r != 2'd0) sq_r <= sq_r + 62'(prod_r);
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          v_r   <= sq_r + 62'(prod_r);
          r_r   <= '0;
          bit_r <= 62'(1) << 60;
        end
      end
      U_ROOT: begin
        if (v_r >= rb) begin
          v_r <= v_r - rb;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          len_r <= (v_r >= rb) ? 31'((r_r >> 1) + bit_r) : 31'(r_r >> 1);
          cnt_r <= 2'd0;
        end
      end
      U_DSET: begin
        rem_r   <= 31'(numer[44:16]);
        num_r   <= numer[15:0];
        q_r     <= '0;
        dstep_r <= '0;
      end
      U_DIV: begin
        rem_r   <= take ? 31'(trial - {1'b0, len_r}) : trial[30:0];
        num_r   <= num_r << 1;
        q_r     <= q_new;
        dstep_r <= dstep_r + 4'd1;
        if (dstep_r == 4'd15) begin
          out_r[cnt_r] <= neg_r[cnt_r] ? -signed'(q_new) : signed'(q_new);
          cnt_r        <= cnt_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign res.busy = (state_r != U_IDLE);
  assign res.done = (state_r == U_DONE);
  assign res.zero = zero_r;
  assign res.nx   = out_r[0];
  assign res.ny   = out_r[1];
  assign res.nz   = out_r[2];

endmodule

// ===== rtl/smooth_vertex_normals.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smooth_vertex_normals
// Per-vertex smooth normals from position and accumulator memories.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A load, an unused command or a rejected
// index goes straight to the response. A read and a triangle both pass
// through the unit-length scaler: its one-bit normalizing shifter, then a
// squared sum, a 31-step square root and three divisions, all one step per
// cycle. A triangle first reads its three positions and forms the cross
// product, and after the scaler does an accumulator read-modify-write per
// corner. A degenerate triangle skips the scaling and the accumulator
// update, and a read of an all-zero accumulator skips the scaling. After
// reset a clearing pass zeroes all MAX_VERTICES accumulators; no item is
// taken during it, while configuration writes are.
module smooth_vertex_normals import svn_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int POS_WIDTH    = POS_WIDTH_DEF,
  parameter int SUM_WIDTH    = SUM_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CNT_W-1:0]          cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_command,
  input  logic [IN_IDXW-1:0]        in_first_index,
  input  logic [IN_IDXW-1:0]        in_second_index,
  input  logic [IN_IDXW-1:0]        in_third_index,
  input  logic signed [IN_POSW-1:0] in_pos_x,
  input  logic signed [IN_POSW-1:0] in_pos_y,
  input  logic signed [IN_POSW-1:0] in_pos_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [NRM_W-1:0]   out_normal_x,
  output logic signed [NRM_W-1:0]   out_normal_y,
  output logic signed [NRM_W-1:0]   out_normal_z,
  output logic [1:0]                out_status
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int EW    = POS_WIDTH + 1;
  localparam int PW    = 2 * EW;
  localparam int VEC_W = (2*POS_WIDTH+3 > SUM_WIDTH) ? 2*POS_WIDTH+3 : SUM_WIDTH;

  svn_state_t state_r, state_nxt;

  logic [CNT_W-1:0] vcount_r;
  logic [IDX_W-1:0] clr_r;
  logic [1:0]       cmd_r;
  logic [1:0]       status_r;
  logic [IDX_W-1:0] i0_r, i1_r, i2_r;
  logic [1:0]       mul_cnt_r;
  logic [1:0]       corner_r;

  logic [3*POS_WIDTH-1:0] pos_mem [MAX_VERTICES];
  logic [3*SUM_WIDTH-1:0] sum_mem [MAX_VERTICES];
  logic [3*POS_WIDTH-1:0] pos_rdata_r;
  logic [3*SUM_WIDTH-1:0] sum_rdata_r;
  logic [3*POS_WIDTH-1:0] pos_wdata;
  logic [3*SUM_WIDTH-1:0] sum_wdata;
  logic                   pos_we, sum_we;
  logic [IDX_W-1:0]       pos_raddr, sum_raddr, sum_waddr, corner_addr;

  logic [3*POS_WIDTH-1:0] p0_r, p1_r;
  logic signed [EW-1:0]   e1_r [3];
  logic signed [EW-1:0]   e2_r [3];
  logic signed [PW-1:0]   pa_r, pb_r;
  logic signed [VEC_W-1:0] vec_r [3];

  logic      ok0, ok1, ok2;
  logic      in_accept;
  logic      u_start;
  logic      out_load;
  logic      show;
  unit_res_t u_res;

  logic signed [31:0] px32, py32, pz32;

  function automatic logic idx_ok(input logic [IN_IDXW-1:0] idx,
                                  input logic [CNT_W-1:0] cnt);
    return (CNT_W'(idx) < cnt) && (32'(idx) < MAX_VERTICES);
  endfunction

  function automatic logic signed [SUM_WIDTH-1:0] sat_add(
      input logic signed [SUM_WIDTH-1:0] a, input logic signed [NRM_W-1:0] b);
    logic signed [SUM_WIDTH:0] s;
    s = (SUM_WIDTH+1)'(a) + (SUM_WIDTH+1)'(b);
    if (s[SUM_WIDTH] != s[SUM_WIDTH-1])
      return s[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    return s[SUM_WIDTH-1:0];
  endfunction

  assign ok0 = idx_ok(in_first_index, vcount_r);
  assign ok1 = idx_ok(in_second_index, vcount_r);
  assign ok2 = idx_ok(in_third_index, vcount_r);
  assign in_accept = in_valid && !in_stall;

  // Positions wrap to POS_WIDTH bits when stored.
  assign px32 = 32'(in_pos_x);
  assign py32 = 32'(in_pos_y);
  assign pz32 = 32'(in_pos_z);
  assign pos_wdata = {pz32[POS_WIDTH-1:0], py32[POS_WIDTH-1:0], px32[POS_WIDTH-1:0]};

  always_comb begin
    case (corner_r)
      2'd0:    corner_addr = i0_r;
      2'd1:    corner_addr = i1_r;
      default: corner_addr = i2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= VCOUNT_RESET;
    else if (cfg_wr_en) vcount_r <= cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    pos_we    = 1'b0;
    sum_we    = 1'b0;
    sum_waddr = clr_r;
    sum_wdata = '0;
    pos_raddr = i0_r;
    sum_raddr = i0_r;
    u_start   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        sum_we = 1'b1;
        if (clr_r == IDX_W'(MAX_VERTICES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = S_RESP;
          case (in_command)
            CMD_LOAD: begin
              if (ok0) begin
                pos_we    = 1'b1;
                sum_we    = 1'b1;
                sum_waddr = IDX_W'(in_first_index);
              end
            end
            CMD_TRI:  if (ok0 && ok1 && ok2) state_nxt = S_POS0;
            CMD_READ: if (ok0) state_nxt = S_SUMRD;
            default: ;
          endcase
        end
      end
      S_POS0: begin pos_raddr = i0_r; state_nxt = S_POS1; end
      S_POS1: begin pos_raddr = i1_r; state_nxt = S_POS2; end
      S_POS2: begin pos_raddr = i2_r; state_nxt = S_POS3; end
      S_POS3: state_nxt = S_MUL;
      S_MUL:  if (mul_cnt_r == 2'd3) state_nxt = S_START;
      S_SUMRD: begin sum_raddr = i0_r; state_nxt = S_SUMCAP; end
      S_SUMCAP: state_nxt = S_START;
      S_START: begin u_start = 1'b1; state_nxt = S_WAIT; end
      S_WAIT: begin
        if (u_res.done) begin
          state_nxt = (cmd_r == CMD_TRI && !u_res.zero) ? S_ACCRD : S_RESP;
        end
      end
      S_ACCRD: begin sum_raddr = corner_addr; state_nxt = S_ACCWR; end
      S_ACCWR: begin
        sum_we    = 1'b1;
        sum_waddr = corner_addr;
        sum_wdata = {sat_add(signed'(sum_rdata_r[2*SUM_WIDTH +: SUM_WIDTH]), u_res.nz),
                     sat_add(signed'(sum_rdata_r[SUM_WIDTH +: SUM_WIDTH]), u_res.ny),
                     sat_add(signed'(sum_rdata_r[0 +: SUM_WIDTH]), u_res.nx)};
        state_nxt = (corner_r == 2'd2) ? S_RESP : S_ACCRD;
      end
      S_RESP: begin
        if (!out_valid || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memories: one write and one registered read port each.
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[IDX_W'(in_first_index)] <= pos_wdata;
    pos_rdata_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_rdata_r <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (state_r == S_CLEAR) clr_r <= clr_r + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r     <= in_command;
      i0_r      <= IDX_W'(in_first_index);
      i1_r      <= IDX_W'(in_second_index);
      i2_r      <= IDX_W'(in_third_index);
      mul_cnt_r <= '0;
      corner_r  <= '0;
      case (in_command) inside
        CMD_LOAD, CMD_READ: status_r <= ok0 ? ST_OK : ST_RANGE;
        CMD_TRI:  status_r <= (ok0 && ok1 && ok2) ? ST_OK : ST_RANGE;
        default:  status_r <= ST_OK;
      endcase
    end
    if (state_r == S_POS1) p0_r <= pos_rdata_r;
    if (state_r == S_POS2) p1_r <= pos_rdata_r;
    if (state_r == S_POS3) begin
      for (int k = 0; k < 3; k++) begin
        e1_r[k] <= EW'(signed'(p1_r[k*POS_WIDTH +: POS_WIDTH]))
                 - EW'(signed'(p0_r[k*POS_WIDTH +: POS_WIDTH]));
        e2_r[k] <= EW'(signed'(pos_rdata_r[k*POS_WIDTH +: POS_WIDTH]))
                 - EW'(signed'(p0_r[k*POS_WIDTH +: POS_WIDTH]));
      end
    end
    // Cross product: two products a cycle, subtracted the cycle after.
    if (state_r == S_MUL) begin
      case (mul_cnt_r)
        2'd0: begin pa_r <= e1_r[1] * e2_r[2]; pb_r <= e1_r[2] * e2_r[1]; end
        2'd1: begin pa_r <= e1_r[2] * e2_r[0]; pb_r <= e1_r[0] * e2_r[2]; end
        2'd2: begin pa_r <= e1_r[0] * e2_r[1]; pb_r <= e1_r[1] * e2_r[0]; end
        default: ;
      endcase
      if (mul_cnt_r != 2'd0)
        vec_r[mul_cnt_r - 2'd1] <= VEC_W'((PW+1)'(pa_r) - (PW+1)'(pb_r));
      mul_cnt_r <= mul_cnt_r + 2'd1;
    end
    if (state_r == S_SUMCAP) begin
      for (int k = 0; k < 3; k++)
        vec_r[k] <= VEC_W'(signed'(sum_rdata_r[k*SUM_WIDTH +: SUM_WIDTH]));
    end
    if (state_r == S_WAIT && u_res.done && u_res.zero) status_r <= ST_ZERO;
    if (state_r == S_ACCWR) corner_r <= corner_r + 2'd1;
  end

  svn_unit #(.VEC_W(VEC_W)) u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .start (u_start),
    .vec   (vec_r),
    .res   (u_res)
  );

  assign show = (cmd_r == CMD_READ) && (status_r == ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_normal_x <= show ? u_res.nx : '0;
      out_normal_y <= show ? u_res.ny : '0;
      out_normal_z <= show ? u_res.nz : '0;
      out_status   <= status_r;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    u_start |-> !u_res.busy)
    else $error("scaler started while busy");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_RESP))
    else $error("result raised outside response state");

  a_rmw_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACCWR) |-> (sum_waddr == $past(sum_raddr)))
    else $error("accumulator write address differs from read address");

  a_zero_normal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0))
    else $error("nonzero normal with failing status");

endmodule
